// File: hdl/gdda_pkg.sv
// Shared types and constants for the grid ray caster.
`timescale 1ns / 1ps

package gdda_pkg;

   // Stream payload widths
   localparam int unsigned POS_W     = 18;
   localparam int unsigned DIR_W     = 16;
   localparam int unsigned REQ_W     = 72;
   localparam int unsigned OUT_DST_W = 32;
   localparam int unsigned CELL_W    = 5;
   localparam int unsigned RSP_W     = 48;

   // Configuration registers
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 64;
   localparam int unsigned SIZE_W     = 8;
   localparam int unsigned DIM_W      = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_WALL_MAP   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_SIZE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_HEIGHT = 2'd3;

   localparam logic [CSR_DATA_W-1:0] WALL_MAP_RST   = 64'd33084991;
   localparam logic [SIZE_W-1:0]     CELL_SIZE_RST  = 8'd100;
   localparam logic [DIM_W-1:0]      MAP_WIDTH_RST  = 4'd5;
   localparam logic [DIM_W-1:0]      MAP_HEIGHT_RST = 4'd5;

   // Divider
   localparam int unsigned DIVD_W = 30;
   localparam int unsigned DVS_W  = 16;
   localparam int unsigned CNT_W  = 5;
   localparam logic [CNT_W-1:0] DIV_LONG  = 5'd30;
   localparam logic [CNT_W-1:0] DIV_SHORT = 5'd18;

   typedef enum logic [1:0] {
      OP_CELL,
      OP_DELTA,
      OP_FIRST
   } div_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CELL_GO,
      ST_CELL_WAIT,
      ST_DELTA_GO,
      ST_DELTA_WAIT,
      ST_FIRST_GO,
      ST_FIRST_WAIT,
      ST_WALK,
      ST_HOLD
   } state_type;

   typedef struct packed {
      div_op_type op;
      logic       load_ray;
      logic       div_start;
      logic       div_capture;
      logic       walk_step;
      logic       load_rsp;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic walk_end;
      logic rsp_free;
   } status_type;

endpackage

// File: hdl/gdda_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module gdda_div
   import gdda_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              short_op,
   input  logic [DIVD_W-1:0] dividend,
   input  logic [DVS_W-1:0]  divisor,
   output logic              done,
   output logic [DIVD_W-1:0] quotient,
   output logic [DVS_W-1:0]  remainder
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIVD_W-1:0] dq_ff, dq_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DVS_W:0]    trial;
   logic [DVS_W:0]    diff;

   always_comb begin
      trial   = {rem_ff, dq_ff[DIVD_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = short_op ? DIV_SHORT : DIV_LONG;
         dq_in   = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[DVS_W-1:0];
            dq_in  = {dq_ff[DIVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DVS_W-1:0];
            dq_in  = {dq_ff[DIVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = dq_ff;
   assign remainder = rem_ff;

endmodule

// File: hdl/gdda_ctrl.sv
// Sequencer for the ray caster: divisions, grid walk, result hand-off.
`timescale 1ns / 1ps

module gdda_ctrl
   import gdda_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type sts,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_ray = 1'b1;
               state_in     = ST_CELL_GO;
            end
         end
         ST_CELL_GO: begin
            cmd.op        = OP_CELL;
            cmd.div_start = 1'b1;
            state_in      = ST_CELL_WAIT;
         end
         ST_CELL_WAIT: begin
            cmd.op = OP_CELL;
            if (sts.div_done) begin
               cmd.div_capture = 1'b1;
               state_in        = ST_DELTA_GO;
            end
         end
         ST_DELTA_GO: begin
            cmd.op        = OP_DELTA;
            cmd.div_start = 1'b1;
            state_in      = ST_DELTA_WAIT;
         end
         ST_DELTA_WAIT: begin
            cmd.op = OP_DELTA;
            if (sts.div_done) begin
               cmd.div_capture = 1'b1;
               state_in        = ST_FIRST_GO;
            end
         end
         ST_FIRST_GO: begin
            cmd.op        = OP_FIRST;
            cmd.div_start = 1'b1;
            state_in      = ST_FIRST_WAIT;
         end
         ST_FIRST_WAIT: begin
            cmd.op = OP_FIRST;
            if (sts.div_done) begin
               cmd.div_capture = 1'b1;
               state_in        = ST_WALK;
            end
         end
         ST_WALK: begin
            if (sts.walk_end) begin
               if (sts.rsp_free) begin
                  cmd.load_rsp = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_HOLD;
               end
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         ST_HOLD: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: hdl/gdda_dpath.sv
// Datapath: config registers, per-axis dividers, grid walk, result register.
`timescale 1ns / 1ps

module gdda_dpath
   import gdda_pkg::*;
#(
   parameter int unsigned MAP_SIDE   = 8,
   parameter int unsigned DIST_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_W-1:0]      req_tdata,
   input  cmd_type               cmd,
   output status_type            sts,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata
);

   localparam int unsigned CW = $clog2(MAP_SIDE);
   localparam int unsigned IW = $clog2(MAP_SIDE * MAP_SIDE);
   localparam logic [DIST_WIDTH-1:0] DIST_MAX = '1;
   localparam logic [63:0] OUT_MAX = 64'hFFFF_FFFF;

   // Configuration
   logic [CSR_DATA_W-1:0] wall_ff, wall_in;
   logic [SIZE_W-1:0]     size_ff, size_in;
   logic [DIM_W-1:0]      mapw_ff, mapw_in;
   logic [DIM_W-1:0]      maph_ff, maph_in;

   // Ray
   logic [POS_W-1:0] px_ff, px_in, py_ff, py_in;
   logic [DIR_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [DVS_W-1:0] remx_ff, remx_in, remy_ff, remy_in;
   logic signed [CELL_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [DIST_WIDTH-1:0] delx_ff, delx_in, dely_ff, dely_in;
   logic [DIST_WIDTH-1:0] sidex_ff, sidex_in, sidey_ff, sidey_in;
   logic [DIST_WIDTH-1:0] dist_ff, dist_in;
   logic vert_ff, vert_in, hit_ff, hit_in;

   // Result register
   logic                 rvalid_ff, rvalid_in;
   logic [RSP_W-1:0]     rdata_ff, rdata_in;

   // Derived values
   logic [SIZE_W-1:0]  side_px;
   logic [DVS_W-1:0]   cq8;
   logic [DIM_W-1:0]   w_c, h_c;
   logic               dx_pos, dy_pos;
   logic [DVS_W-1:0]   magx, magy;
   logic [DVS_W-1:0]   numx, numy;
   logic [DIVD_W-1:0]  divd_x, divd_y;
   logic [DVS_W-1:0]   dvs_x, dvs_y;
   logic               short_op;
   logic               done_x, done_y;
   logic [DIVD_W-1:0]  qx, qy;
   logic [DVS_W-1:0]   rx, ry;
   logic               x_less;
   logic signed [CELL_W-1:0] nx, ny;
   logic [IW-1:0]      widx;
   logic [DIST_WIDTH:0] sum_x, sum_y;
   logic [63:0]        dist64;

   function automatic logic [DIST_WIDTH-1:0] sat_q(input logic [DIVD_W-1:0] q);
      logic [63:0] q64;
      q64 = 64'(q);
      return (q64 > 64'(DIST_MAX)) ? DIST_MAX : DIST_WIDTH'(q64);
   endfunction

   function automatic logic signed [CELL_W-1:0] sat_cell(input logic [DIVD_W-1:0] q);
      return (|q[DIVD_W-1:CELL_W-1]) ? CELL_W'(15) : {1'b0, q[CELL_W-2:0]};
   endfunction

   function automatic logic in_map(input logic signed [CELL_W-1:0] c,
                                   input logic [DIM_W-1:0] lim);
      return !c[CELL_W-1] && (c[CELL_W-2:0] < lim);
   endfunction

   function automatic logic [DVS_W-1:0] mag(input logic [DIR_W-1:0] d);
      return d[DIR_W-1] ? DVS_W'(-d) : DVS_W'(d);
   endfunction

   always_comb begin
      side_px = (size_ff == '0) ? SIZE_W'(1) : size_ff;
      cq8    = {side_px, 8'd0};
      w_c    = (mapw_ff > DIM_W'(MAP_SIDE)) ? DIM_W'(MAP_SIDE) : mapw_ff;
      h_c    = (maph_ff > DIM_W'(MAP_SIDE)) ? DIM_W'(MAP_SIDE) : maph_ff;
      dx_pos = !dx_ff[DIR_W-1] && (dx_ff != '0);
      dy_pos = !dy_ff[DIR_W-1] && (dy_ff != '0);
      magx   = mag(dx_ff);
      magy   = mag(dy_ff);
      numx   = dx_pos ? (cq8 - remx_ff) : remx_ff;
      numy   = dy_pos ? (cq8 - remy_ff) : remy_ff;
      short_op = 1'b0;
      case (cmd.op)
         OP_CELL: begin
            divd_x   = {px_ff, 12'd0};
            divd_y   = {py_ff, 12'd0};
            dvs_x    = cq8;
            dvs_y    = cq8;
            short_op = 1'b1;
         end
         OP_DELTA: begin
            divd_x = {side_px, 22'd0};
            divd_y = {side_px, 22'd0};
            dvs_x  = magx;
            dvs_y  = magy;
         end
         OP_FIRST: begin
            divd_x = {numx, 14'd0};
            divd_y = {numy, 14'd0};
            dvs_x  = magx;
            dvs_y  = magy;
         end
         default: begin
            divd_x = '0;
            divd_y = '0;
            dvs_x  = '0;
            dvs_y  = '0;
         end
      endcase
   end

   gdda_div u_div_x (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .short_op  (short_op),
      .dividend  (divd_x),
      .divisor   (dvs_x),
      .done      (done_x),
      .quotient  (qx),
      .remainder (rx)
   );

   gdda_div u_div_y (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .short_op  (short_op),
      .dividend  (divd_y),
      .divisor   (dvs_y),
      .done      (done_y),
      .quotient  (qy),
      .remainder (ry)
   );

   // One grid step: nearer line wins, ties go to y.
   always_comb begin
      x_less = sidex_ff < sidey_ff;
      sum_x  = {1'b0, sidex_ff} + {1'b0, delx_ff};
      sum_y  = {1'b0, sidey_ff} + {1'b0, dely_ff};
      nx     = cx_ff;
      ny     = cy_ff;
      if (x_less) begin
         nx = dx_pos ? (cx_ff + CELL_W'(1)) : (cx_ff - CELL_W'(1));
      end else begin
         ny = dy_pos ? (cy_ff + CELL_W'(1)) : (cy_ff - CELL_W'(1));
      end
      widx = IW'(ny[CW-1:0]) * IW'(w_c) + IW'(nx[CW-1:0]);
   end

   always_comb begin
      wall_in = wall_ff;
      size_in = size_ff;
      mapw_in = mapw_ff;
      maph_in = maph_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_WALL_MAP:   wall_in = csr_data;
            CSR_CELL_SIZE:  size_in = csr_data[SIZE_W-1:0];
            CSR_MAP_WIDTH:  mapw_in = csr_data[DIM_W-1:0];
            CSR_MAP_HEIGHT: maph_in = csr_data[DIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      px_in    = px_ff;
      py_in    = py_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      remx_in  = remx_ff;
      remy_in  = remy_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      delx_in  = delx_ff;
      dely_in  = dely_ff;
      sidex_in = sidex_ff;
      sidey_in = sidey_ff;
      dist_in  = dist_ff;
      vert_in  = vert_ff;
      hit_in   = hit_ff;
      if (cmd.load_ray) begin
         px_in   = req_tdata[17:0];
         py_in   = req_tdata[35:18];
         dx_in   = req_tdata[51:36];
         dy_in   = req_tdata[67:52];
         dist_in = '0;
         vert_in = 1'b0;
         hit_in  = 1'b0;
      end
      if (cmd.div_capture) begin
         case (cmd.op)
            OP_CELL: begin
               cx_in   = sat_cell(qx);
               cy_in   = sat_cell(qy);
               remx_in = rx;
               remy_in = ry;
            end
            OP_DELTA: begin
               delx_in = (dx_ff == '0) ? DIST_MAX : sat_q(qx);
               dely_in = (dy_ff == '0) ? DIST_MAX : sat_q(qy);
            end
            OP_FIRST: begin
               sidex_in = (dx_ff == '0) ? DIST_MAX : sat_q(qx);
               sidey_in = (dy_ff == '0) ? DIST_MAX : sat_q(qy);
            end
            default: begin
            end
         endcase
      end
      if (cmd.walk_step) begin
         cx_in = nx;
         cy_in = ny;
         if (x_less) begin
            dist_in  = sidex_ff;
            sidex_in = sum_x[DIST_WIDTH] ? DIST_MAX : sum_x[DIST_WIDTH-1:0];
            vert_in  = 1'b1;
         end else begin
            dist_in  = sidey_ff;
            sidey_in = sum_y[DIST_WIDTH] ? DIST_MAX : sum_y[DIST_WIDTH-1:0];
            vert_in  = 1'b0;
         end
         hit_in = in_map(nx, w_c) && in_map(ny, h_c) && wall_ff[widx];
      end
   end

   always_comb begin
      dist64    = 64'(dist_ff);
      rvalid_in = rvalid_ff;
      rdata_in  = rdata_ff;
      if (cmd.load_rsp) begin
         rvalid_in = 1'b1;
         rdata_in  = {4'd0, hit_ff, vert_ff, cy_ff, cx_ff,
                      (dist64 > OUT_MAX) ? 32'hFFFF_FFFF : dist64[OUT_DST_W-1:0]};
      end else if (rsp_tready) begin
         rvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wall_ff   <= WALL_MAP_RST;
         size_ff   <= CELL_SIZE_RST;
         mapw_ff   <= MAP_WIDTH_RST;
         maph_ff   <= MAP_HEIGHT_RST;
         rvalid_ff <= 1'b0;
      end else begin
         wall_ff   <= wall_in;
         size_ff   <= size_in;
         mapw_ff   <= mapw_in;
         maph_ff   <= maph_in;
         rvalid_ff <= rvalid_in;
      end
      px_ff    <= px_in;
      py_ff    <= py_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      remx_ff  <= remx_in;
      remy_ff  <= remy_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      delx_ff  <= delx_in;
      dely_ff  <= dely_in;
      sidex_ff <= sidex_in;
      sidey_ff <= sidey_in;
      dist_ff  <= dist_in;
      vert_ff  <= vert_in;
      hit_ff   <= hit_in;
      rdata_ff <= rdata_in;
   end

   assign sts.div_done = done_x && done_y;
   assign sts.walk_end = hit_ff || !in_map(cx_ff, w_c) || !in_map(cy_ff, h_c);
   assign sts.rsp_free = !rvalid_ff || rsp_tready;

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = rdata_ff;

endmodule

// File: hdl/grid_ray_traversal_dda.sv
// Top level of the grid ray caster.
`timescale 1ns / 1ps

// Casts one ray per request beat over a map of up to MAP_SIDE by MAP_SIDE square
// cells and returns one response beat with the distance to the last crossed grid
// line, the final cell, the crossing axis and a wall hit flag. One ray is in
// work at a time. x and y run in two parallel restoring dividers at one quotient
// bit per cycle through three divisions: start cell (18 bits), step distance (30)
// and first line distance (30), each with a start state and a wait state. A ray is
// accepted in the idle state; after the divisions the grid walk steps until a wall
// is hit or the ray leaves the map, and the result then goes to the output
// register, waiting while that register is full. The next ray is taken while the
// previous response still waits in the output register. Configuration writes
// are always ready and must only be issued while no ray is in work.

module grid_ray_traversal_dda
   import gdda_pkg::*;
#(
   parameter int unsigned MAP_SIDE   = 8,
   parameter int unsigned DIST_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,  // pos_x, pos_y, dir_cos, dir_sin, pad
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,  // distance, cell_x, cell_y,
                                             // vertical_side, wall_hit, pad
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cmd_type    cmd;
   status_type sts;

   assign csr_ready = 1'b1;

   gdda_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   gdda_dpath #(
      .MAP_SIDE   (MAP_SIDE),
      .DIST_WIDTH (DIST_WIDTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: tb/tb_grid_ray_traversal_dda.sv
// Self-checking testbench for the grid ray caster: directed and random rays over many map setups.
`timescale 1ns / 1ps

module tb_grid_ray_traversal_dda
   import gdda_pkg::*;
();

   localparam int unsigned MAP_SIDE   = 8;
   localparam int unsigned DIST_WIDTH = 32;
   localparam longint unsigned DIST_MAX = (64'd1 << DIST_WIDTH) - 64'd1;
   localparam longint unsigned POS_MAX  = (64'd1 << POS_W) - 64'd1;

   typedef struct packed {
      logic        [POS_W-1:0] pos_x;
      logic        [POS_W-1:0] pos_y;
      logic signed [DIR_W-1:0] dir_cos;
      logic signed [DIR_W-1:0] dir_sin;
   } ray_type;

   typedef struct packed {
      logic [OUT_DST_W-1:0] distance;
      logic [CELL_W-1:0]    cell_x;
      logic [CELL_W-1:0]    cell_y;
      logic                 vertical_side;
      logic                 wall_hit;
   } cast_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata  = '0;  // pos_x, pos_y, dir_cos, dir_sin, pad
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;        // distance, cell_x, cell_y,
                                            // vertical_side, wall_hit, pad
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = CSR_WALL_MAP;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   // shadow of the block's registers
   logic [CSR_DATA_W-1:0] map_bits = WALL_MAP_RST;
   logic [SIZE_W-1:0]     cell_px  = CELL_SIZE_RST;
   logic [DIM_W-1:0]      map_cols = MAP_WIDTH_RST;
   logic [DIM_W-1:0]      map_rows = MAP_HEIGHT_RST;

   cast_type pending_casts[$];
   cast_type got_cast;
   cast_type want_cast;

   int burst_left   = 0;
   int rays_sent    = 0;
   int casts_seen   = 0;
   int walls_hit    = 0;
   int map_settings = 1;
   int mismatches   = 0;

   logic [5:0]  stall_phase = '0;
   logic [1:0]  stall_mode  = '0;
   logic [63:0] stall_pat   = '1;

   grid_ray_traversal_dda #(
      .MAP_SIDE   (MAP_SIDE),
      .DIST_WIDTH (DIST_WIDTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic longint unsigned dist_sat(input longint unsigned v);
      return (v > DIST_MAX) ? DIST_MAX : v;
   endfunction

   function automatic longint unsigned dir_mag(input logic signed [DIR_W-1:0] d);
      return (d < 0) ? longint'(-int'(d)) : longint'(d);
   endfunction

   // distance along the ray to the first grid line out of the start cell
   function automatic longint unsigned first_boundary(input longint unsigned pos,
                                                      input longint unsigned cq8,
                                                      input int idx,
                                                      input logic signed [DIR_W-1:0] d);
      longint unsigned span;
      if (d == 0)
         return DIST_MAX;
      if (d > 0)
         span = longint'(idx + 1) * cq8 - pos;
      else
         span = pos - longint'(idx) * cq8;
      return dist_sat((span << 14) / dir_mag(d));
   endfunction

   function automatic cast_type cast_ray(input ray_type r);
      longint unsigned cell_len, cq8, step_x_len, step_y_len, next_x, next_y, travel;
      int cx, cy, dir_x, dir_y, cols, rows;
      bit vert, hit;
      cast_type res;
      cell_len = (cell_px == 0) ? 64'd1 : 64'(cell_px);
      cq8 = cell_len << 8;
      cols = (map_cols > MAP_SIDE) ? MAP_SIDE : int'(map_cols);
      rows = (map_rows > MAP_SIDE) ? MAP_SIDE : int'(map_rows);
      cx = int'(64'(r.pos_x) / cq8);
      cy = int'(64'(r.pos_y) / cq8);
      dir_x = (r.dir_cos > 0) ? 1 : -1;
      dir_y = (r.dir_sin > 0) ? 1 : -1;
      step_x_len = (r.dir_cos == 0) ? DIST_MAX : dist_sat((cell_len << 22) / dir_mag(r.dir_cos));
      step_y_len = (r.dir_sin == 0) ? DIST_MAX : dist_sat((cell_len << 22) / dir_mag(r.dir_sin));
      next_x = first_boundary(64'(r.pos_x), cq8, cx, r.dir_cos);
      next_y = first_boundary(64'(r.pos_y), cq8, cy, r.dir_sin);
      travel = 0;
      vert = 1'b0;
      hit = 1'b0;
      while (!hit && cx >= 0 && cx < cols && cy >= 0 && cy < rows) begin
         if (next_x < next_y) begin
            travel = next_x;
            next_x = dist_sat(next_x + step_x_len);
            cx += dir_x;
            vert = 1'b1;
         end else begin
            // ties go to y
            travel = next_y;
            next_y = dist_sat(next_y + step_y_len);
            cy += dir_y;
            vert = 1'b0;
         end
         if (cx >= 0 && cx < cols && cy >= 0 && cy < rows)
            hit = map_bits[(cy * cols + cx) & 63];
      end
      res.distance = travel[OUT_DST_W-1:0];
      res.cell_x = (cx > 15) ? 5'd15 : cx[CELL_W-1:0];
      res.cell_y = (cy > 15) ? 5'd15 : cy[CELL_W-1:0];
      res.vertical_side = vert;
      res.wall_hit = hit;
      return res;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic ray_type ray_of(input longint unsigned px, input longint unsigned py,
                                      input int dx, input int dy);
      ray_type r;
      r.pos_x = px[POS_W-1:0];
      r.pos_y = py[POS_W-1:0];
      r.dir_cos = dx[DIR_W-1:0];
      r.dir_sin = dy[DIR_W-1:0];
      return r;
   endfunction

   function automatic longint unsigned pos_clip(input longint unsigned v);
      return (v > POS_MAX) ? POS_MAX : v;
   endfunction

   function automatic int rand_dir();
      case ($urandom_range(0, 13))
         0:       return 0;
         1:       return 16384;
         2:       return -16384;
         3:       return 1;
         4:       return -1;
         5:       return ($urandom_range(0, 1) != 0) ? 11585 : -11585;
         default: return int'($urandom_range(0, 32768)) - 16384;
      endcase
   endfunction

   function automatic longint unsigned rand_pos(input longint unsigned cq8, input int lines);
      case ($urandom_range(0, 19))
         0, 1:    return $urandom_range(0, POS_MAX);
         2, 3:    return pos_clip(longint'($urandom_range(0, lines)) * cq8);
         default: return $urandom_range(0, pos_clip(longint'(lines) * cq8 - 1));
      endcase
   endfunction

   function automatic ray_type make_ray();
      longint unsigned cq8;
      cq8 = ((cell_px == 0) ? 64'd1 : 64'(cell_px)) << 8;
      return ray_of(rand_pos(cq8, int'(map_cols)), rand_pos(cq8, int'(map_rows)),
                    rand_dir(), rand_dir());
   endfunction

   task automatic send_ray(input ray_type r);
      int gap;
      if (burst_left == 0) begin
         case ($urandom_range(0, 5))
            0, 1:    gap = 0;
            5:       gap = $urandom_range(20, 150);
            default: gap = $urandom_range(1, 12);
         endcase
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_tdata  <= {{(REQ_W - 2*POS_W - 2*DIR_W){1'b0}},
                     r.dir_sin, r.dir_cos, r.pos_y, r.pos_x};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_casts.push_back(cast_ray(r));
      rays_sent++;
      burst_left--;
   endtask

   task automatic drain_rays();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_casts.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_WALL_MAP:   map_bits = value;
         CSR_CELL_SIZE:  cell_px  = value[SIZE_W-1:0];
         CSR_MAP_WIDTH:  map_cols = value[DIM_W-1:0];
         CSR_MAP_HEIGHT: map_rows = value[DIM_W-1:0];
         default: begin
         end
      endcase
   endtask

   task automatic load_map(input logic [63:0] walls, input int size, input int cols,
                           input int rows);
      drain_rays();
      write_csr(CSR_WALL_MAP, walls);
      write_csr(CSR_CELL_SIZE, 64'(size));
      write_csr(CSR_MAP_WIDTH, 64'(cols));
      write_csr(CSR_MAP_HEIGHT, 64'(rows));
      csr_valid <= 1'b0;
      map_settings++;
   endtask

   task automatic random_rays(input int count);
      for (int i = 0; i < count; i++)
         send_ray(make_ray());
   endtask

   // ---------------------------------------------------------------- tests

   // reset map: 5x5, 100 px cells, solid border plus a center wall
   task automatic test_directed_rays();
      send_ray(ray_of(38400, 38400, 16384, 0));
      send_ray(ray_of(38400, 38400, -16384, 0));
      send_ray(ray_of(38400, 38400, 0, 16384));
      send_ray(ray_of(89600, 89600, 0, -16384));
      send_ray(ray_of(89600, 38400, 0, 0));              // no direction: walks -y
      send_ray(ray_of(38400, 38400, 11585, 11585));      // tie at the corner
      send_ray(ray_of(89600, 89600, -11585, -11585));
      send_ray(ray_of(25600, 38400, -16384, 0));         // on a grid line, zero first leg
      send_ray(ray_of(0, 0, 16384, 16384));              // start in a wall
      send_ray(ray_of(64000, 64000, 16384, 0));          // start in the center wall
      send_ray(ray_of(POS_MAX, POS_MAX, -16384, -16384)); // start outside
      send_ray(ray_of(128000, 38400, -16384, 0));        // just past the right edge
      send_ray(ray_of(38400, POS_MAX, 0, -16384));
      send_ray(ray_of(38400, 89600, 1, 16384));
      send_ray(ray_of(89600, 38400, -16384, -1));
      send_ray(ray_of(38400, 38400, 16384, -16384));
      send_ray(ray_of(89600, 89600, -1, 1));
      send_ray(ray_of(51199, 76800, -16384, 5));
      send_ray(ray_of(76800, 51200, 9000, -13700));
   endtask

   task automatic test_default_map_rays();
      random_rays(130);
   endtask

   task automatic test_fine_grid();
      load_map({$urandom() & $urandom(), $urandom() & $urandom()}, 1, 8, 8);
      random_rays(130);
   endtask

   task automatic test_single_cell_map();
      load_map({$urandom(), $urandom()}, 128, 1, 1);
      random_rays(100);
   endtask

   task automatic test_open_map();
      load_map(64'd0, 128, 8, 8);
      random_rays(140);
   endtask

   task automatic test_solid_map();
      load_map({64{1'b1}}, 2, 8, 8);
      random_rays(100);
   endtask

   task automatic test_narrow_maps();
      load_map({$urandom() & $urandom(), $urandom() & $urandom()}, 64, 1, 8);
      random_rays(100);
      load_map({$urandom() & $urandom(), $urandom() & $urandom()}, 50, 8, 1);
      random_rays(100);
   endtask

   task automatic test_random_settings();
      logic [63:0] walls;
      for (int k = 0; k < 5; k++) begin
         walls = {$urandom(), $urandom()};
         if ($urandom_range(0, 1) != 0)
            walls &= {$urandom(), $urandom()};
         load_map(walls, $urandom_range(1, 128), $urandom_range(1, 8), $urandom_range(1, 8));
         random_rays(110);
      end
   endtask

   // ---------------------------------------------------------------- response side

   always @(posedge clock) begin
      stall_phase <= stall_phase + 6'd1;
      if (stall_phase == 6'd0) begin
         stall_mode <= 2'($urandom_range(0, 2));
         stall_pat  <= {$urandom(), $urandom()};
      end
      if (reset)
         rsp_tready <= 1'b0;
      else begin
         case (stall_mode)
            2'd0:    rsp_tready <= 1'b1;
            2'd1:    rsp_tready <= stall_pat[stall_phase];
            default: rsp_tready <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      if (mismatches < 40)
         $display("%0t cast %0d %s: got 0x%0h, want 0x%0h", $realtime, casts_seen, what,
                  got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_cast = rsp_tdata[$bits(cast_type)-1:0];
         got_cast = {got_cast.wall_hit, got_cast.vertical_side, got_cast.cell_y,
                     got_cast.cell_x, got_cast.distance};
         got_cast.distance      = rsp_tdata[31:0];
         got_cast.cell_x        = rsp_tdata[36:32];
         got_cast.cell_y        = rsp_tdata[41:37];
         got_cast.vertical_side = rsp_tdata[42];
         got_cast.wall_hit      = rsp_tdata[43];
         if (pending_casts.size() == 0)
            report_mismatch("unexpected beat, distance", got_cast.distance, 0);
         else begin
            want_cast = pending_casts.pop_front();
            if (got_cast.distance !== want_cast.distance)
               report_mismatch("distance", got_cast.distance, want_cast.distance);
            if (got_cast.cell_x !== want_cast.cell_x)
               report_mismatch("cell_x", got_cast.cell_x, want_cast.cell_x);
            if (got_cast.cell_y !== want_cast.cell_y)
               report_mismatch("cell_y", got_cast.cell_y, want_cast.cell_y);
            if (got_cast.vertical_side !== want_cast.vertical_side)
               report_mismatch("vertical_side", got_cast.vertical_side,
                               want_cast.vertical_side);
            if (got_cast.wall_hit !== want_cast.wall_hit)
               report_mismatch("wall_hit", got_cast.wall_hit, want_cast.wall_hit);
            if (want_cast.wall_hit)
               walls_hit++;
         end
         casts_seen++;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed_rays();
      test_default_map_rays();
      test_fine_grid();
      test_single_cell_map();
      test_open_map();
      test_solid_map();
      test_narrow_maps();
      test_random_settings();
      drain_rays();
      repeat (200) @(posedge clock);
      $display("Cast %0d rays over %0d map setups, %0d beats checked.", rays_sent,
               map_settings, casts_seen);
      $display("%0d rays ended in a wall, %0d left the map; %0d mismatches.", walls_hit,
               casts_seen - walls_hit, mismatches);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
